/* sv/mesf_pkg.sv */
`timescale 1ns / 1ps

package mesf_pkg;

  // Parameter defaults
  localparam int MAX_RADIUS_DEF = 1023;
  localparam int COORD_BITS_DEF = 16;

  // Field and state widths
  localparam int RAD_W  = 10;
  localparam int RSQ_W  = 20;
  localparam int STEP_W = 11;
  localparam int TERM_W = 34;
  localparam int DEC_W  = 48;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Item kinds
  localparam logic KIND_BEGIN   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN2,
    ST_STEP_DEC,
    ST_B_SQX,
    ST_B_SQY,
    ST_B_CROSS,
    ST_B_P1,
    ST_QUARTER_1,
    ST_T_A1,
    ST_T_A2,
    ST_T_B1,
    ST_T_B2,
    ST_T_C,
    ST_T_SUM,
    ST_QUARTER_2
  } state_e;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  // Divide by four, truncating toward zero
  function automatic logic signed [DEC_W-1:0] quarter_trunc(input logic signed [DEC_W-1:0] v);
    logic signed [DEC_W-1:0] biased;
    biased = v[DEC_W-1] ? (v + DEC_W'(3)) : v;
    return biased >>> 2;
  endfunction

endpackage

/* sv/mesf_mul.sv */
`timescale 1ns / 1ps

module mesf_mul
  import mesf_pkg::*;
(
  input  logic                     clk_i,
  input  mul_req_t                 req_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // Signed product, registered on request
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= $signed(req_i.a) * $signed(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

/* sv/midpoint_ellipse_span_fill.sv */
`timescale 1ns / 1ps
// Begin: set-up runs ST_B_SQX to ST_QUARTER_1, on to ST_QUARTER_2 when region 1 is skipped;
// next transaction taken in ST_IDLE. Advance: first span registered on acceptance, second once
// the first is taken; ready in ST_IDLE, later when the step ends region 1 (plus output stall).
// Set-up cost comes from the single shared multiplier, one product per cycle.
// rst_ni (asynchronous, active low) leaves the block idle with no ellipse active.

module midpoint_ellipse_span_fill
  import mesf_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input transactions
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic        [RAD_W-1:0]      radius_x_i,
  input  logic        [RAD_W-1:0]      radius_y_i,
  // output transactions
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS:0]   span_left_o,
  output logic signed [COORD_BITS:0]   span_right_o,
  output logic signed [COORD_BITS:0]   span_row_o,
  output logic                         last_o
);

  localparam int OUT_W = COORD_BITS + 1;

  state_e state_q, state_d;

  logic active_q, in_region_two_q;
  logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q;
  logic [RAD_W-1:0]         rx_q;
  logic [RSQ_W-1:0]         rx_sq_q, ry_sq_q;
  logic [STEP_W-1:0]        step_x_q;
  logic signed [STEP_W-1:0] step_y_q;
  logic signed [TERM_W-1:0] px_q, py_q;
  logic signed [DEC_W-1:0]  decision_q, acc_q;

  logic                    out_valid_q, last_q;
  logic signed [OUT_W-1:0] span_left_q, span_right_q, span_row_q;

  logic                     in_acc, out_free, span_load;
  logic [RAD_W-1:0]         rad_x_sat, rad_y_sat;
  logic signed [STEP_W-1:0] y_minus_one;
  logic                     dec_pos;
  logic                     at_last;
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Radius clamp
  assign rad_x_sat = (32'(radius_x_i) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_x_i;
  assign rad_y_sat = (32'(radius_y_i) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_y_i;

  assign y_minus_one = step_y_q - STEP_W'(1);
  assign dec_pos     = !decision_q[DEC_W-1] && (decision_q != '0);
  assign at_last     = in_region_two_q && (step_y_q[STEP_W-1] || (step_y_q == '0));

  mesf_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_BEGIN) begin
            state_d = ST_B_SQX;
          end else if (active_q) begin
            state_d = ST_SPAN2;
          end
        end
      end
      ST_SPAN2: begin
        if (out_free) state_d = ST_STEP_DEC;
      end
      ST_STEP_DEC: begin
        state_d = (!in_region_two_q && (px_q >= py_q)) ? ST_T_A1 : ST_IDLE;
      end
      ST_B_SQX:     state_d = ST_B_SQY;
      ST_B_SQY:     state_d = ST_B_CROSS;
      ST_B_CROSS:   state_d = ST_B_P1;
      ST_B_P1:      state_d = ST_QUARTER_1;
      ST_QUARTER_1: state_d = (px_q >= py_q) ? ST_T_A1 : ST_IDLE;
      ST_T_A1:      state_d = ST_T_A2;
      ST_T_A2:      state_d = ST_T_B1;
      ST_T_B1:      state_d = ST_T_B2;
      ST_T_B2:      state_d = ST_T_C;
      ST_T_C:       state_d = ST_T_SUM;
      ST_T_SUM:     state_d = ST_QUARTER_2;
      ST_QUARTER_2: state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: multiplier requests and span loads
  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = '0;
    mul_req.b  = '0;
    span_load  = 1'b0;
    unique case (state_q)
      ST_IDLE:  span_load = in_acc && (kind_i == KIND_ADVANCE) && active_q;
      ST_SPAN2: span_load = out_free;
      ST_B_SQX: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(rx_q);
        mul_req.b  = MUL_B_W'(rx_q);
      end
      ST_B_SQY: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(step_y_q);
        mul_req.b  = MUL_B_W'(step_y_q);
      end
      ST_B_CROSS: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(rx_sq_q);
        mul_req.b  = MUL_B_W'(step_y_q);
      end
      ST_T_A1: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(ry_sq_q);
        mul_req.b  = MUL_B_W'({step_x_q, 1'b1});
      end
      ST_T_A2: begin
        mul_req.en = 1'b1;
        mul_req.a  = prod[MUL_A_W-1:0];
        mul_req.b  = MUL_B_W'({step_x_q, 1'b1});
      end
      ST_T_B1: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(rx_sq_q);
        mul_req.b  = MUL_B_W'(y_minus_one);
      end
      ST_T_B2: begin
        mul_req.en = 1'b1;
        mul_req.a  = prod[MUL_A_W-1:0];
        mul_req.b  = MUL_B_W'(y_minus_one);
      end
      ST_T_C: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(rx_sq_q);
        mul_req.b  = MUL_B_W'(ry_sq_q);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      active_q        <= 1'b0;
      in_region_two_q <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (span_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_IDLE) && in_acc && (kind_i == KIND_BEGIN)) begin
        active_q        <= 1'b1;
        in_region_two_q <= 1'b0;
      end
      if ((state_q == ST_STEP_DEC) && in_region_two_q && step_y_q[STEP_W-1]) begin
        active_q <= 1'b0;
      end
      if (state_q == ST_QUARTER_2) begin
        in_region_two_q <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (kind_i == KIND_BEGIN)) begin
          origin_x_q <= center_x_i;
          origin_y_q <= center_y_i;
          rx_q       <= rad_x_sat;
          step_x_q   <= '0;
          step_y_q   <= STEP_W'(rad_y_sat);
          px_q       <= '0;
        end
        // span at centre row plus y
        if (span_load) begin
          span_left_q  <= OUT_W'(32'(origin_x_q) - 32'(step_x_q));
          span_right_q <= OUT_W'(32'(origin_x_q) + 32'(step_x_q));
          span_row_q   <= OUT_W'(32'(origin_y_q) + 32'(step_y_q));
          last_q       <= 1'b0;
        end
      end
      ST_SPAN2: begin
        if (out_free) begin
          // span at centre row minus y, from the state before the step
          span_left_q  <= OUT_W'(32'(origin_x_q) - 32'(step_x_q));
          span_right_q <= OUT_W'(32'(origin_x_q) + 32'(step_x_q));
          span_row_q   <= OUT_W'(32'(origin_y_q) - 32'(step_y_q));
          last_q       <= at_last;
          if (!in_region_two_q) begin
            step_x_q <= step_x_q + STEP_W'(1);
            px_q     <= px_q + TERM_W'({ry_sq_q, 1'b0});
            if (!decision_q[DEC_W-1]) begin
              step_y_q <= y_minus_one;
              py_q     <= py_q - TERM_W'({rx_sq_q, 1'b0});
            end
          end else begin
            step_y_q <= y_minus_one;
            py_q     <= py_q - TERM_W'({rx_sq_q, 1'b0});
            if (!dec_pos) begin
              step_x_q <= step_x_q + STEP_W'(1);
              px_q     <= px_q + TERM_W'({ry_sq_q, 1'b0});
            end
          end
        end
      end
      ST_STEP_DEC: begin
        // px and py already hold their updated values
        if (!in_region_two_q) begin
          if (decision_q[DEC_W-1]) begin
            decision_q <= decision_q + DEC_W'(ry_sq_q) + DEC_W'(px_q);
          end else begin
            decision_q <= decision_q + DEC_W'(ry_sq_q) + DEC_W'(px_q) - DEC_W'(py_q);
          end
        end else begin
          if (dec_pos) begin
            decision_q <= decision_q + DEC_W'(rx_sq_q) - DEC_W'(py_q);
          end else begin
            decision_q <= decision_q + DEC_W'(rx_sq_q) - DEC_W'(py_q) + DEC_W'(px_q);
          end
        end
      end
      ST_B_SQY:   rx_sq_q <= RSQ_W'(prod);
      ST_B_CROSS: ry_sq_q <= RSQ_W'(prod);
      ST_B_P1: begin
        // 4*p1 = 4*ry^2 - 4*rx^2*ry + rx^2
        py_q  <= TERM_W'(prod) <<< 1;
        acc_q <= (DEC_W'(ry_sq_q) <<< 2) - (DEC_W'(prod) <<< 2) + DEC_W'(rx_sq_q);
      end
      ST_QUARTER_1: decision_q <= quarter_trunc(acc_q);
      // 4*p2 = ry^2*(2x+1)^2 + 4*rx^2*(y-1)^2 - 4*rx^2*ry^2
      ST_T_B1:      acc_q <= DEC_W'(prod);
      ST_T_C:       acc_q <= acc_q + (DEC_W'(prod) <<< 2);
      ST_T_SUM:     acc_q <= acc_q - (DEC_W'(prod) <<< 2);
      ST_QUARTER_2: decision_q <= quarter_trunc(acc_q);
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign span_left_o  = span_left_q;
  assign span_right_o = span_right_q;
  assign span_row_o   = span_row_q;
  assign last_o       = last_q;

  // Region 1 at rest must still have px below py
  a_region_one_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && active_q && !in_region_two_q |-> (px_q < py_q))
    else $error("region 1 idle with px >= py");

  // Region 2 keeps y non-negative outside the decision step
  a_region_two_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && active_q && in_region_two_q |-> !step_y_q[STEP_W-1])
    else $error("active ellipse with negative y");

  // Second span only while an ellipse runs
  a_span2_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPAN2) || (state_q == ST_STEP_DEC) |-> active_q)
    else $error("advance step without an active ellipse");

  // The final span is always the second of a pair and ends the ellipse
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_load && (state_q == ST_SPAN2) && at_last |=> ##1 !active_q)
    else $error("last span given but ellipse still active");

endmodule
